FILE: sv/remote_link_receiver_unit_defines.svh
// Assertion macros shared by the remote link receiver RTL.
// Each use expects aclk and aresetn in scope of the including module.
`ifndef REMOTE_LINK_RECEIVER_UNIT_DEFINES_SVH
`define REMOTE_LINK_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication
`define RLR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RLR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/rlr_pkg.sv
// Types and constants for the remote link receiver.
// No dependencies; imported by rlr_step and remote_link_receiver_unit.
`default_nettype none

package rlr_pkg;

    localparam int unsigned IDX_W = 3;
    localparam int unsigned ACC_W = 64;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [7:0] CH_PONG  = 8'h56;  // 'V'
    localparam logic [7:0] CH_KEY   = 8'h4B;  // 'K'
    localparam logic [7:0] CH_RADIO = 8'h52;  // 'R'
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam int unsigned HOLD_BIT = 7;

    localparam logic [7:0] CNT_SAT      = 8'hFF;
    localparam logic [7:0] PONG_MIN     = 8'd1;
    localparam logic [7:0] SETUP_LIMIT  = 8'd2;
    localparam logic [1:0] DIV_LAST     = 2'd3;
    localparam logic [7:0] MAX_MISS_RST = 8'd3;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_UP   = 2'd1;
    localparam logic [1:0] EV_DOWN = 2'd2;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_KEY   = 2'd1,
        CMD_RADIO = 2'd2
    } rlr_cmd_t;

    typedef struct packed {
        logic            link_up;
        rlr_cmd_t        cmd_mode;
        logic [IDX_W-1:0] param_index;
        logic [7:0]      missed;
        logic [7:0]      pong;
        logic [1:0]      div;
        logic            sup;
        logic            hold;
    } rlr_state_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } rlr_in_t;

    typedef struct packed {
        logic        send_ping;
        logic [6:0]  key_events;
        logic        hold_on;
        logic [1:0]  link_event;
        logic        radio_valid;
        logic [39:0] radio_word;
        logic        unknown_byte;
        logic        link_up;
    } rlr_out_t;

endpackage

`default_nettype wire

FILE: sv/remote_link_receiver_unit.sv
// Remote link receiver top level: input register, link state, radio byte store,
// result register. Depends on rlr_pkg, rlr_step and remote_link_receiver_unit_defines.svh.
//
// Usage:
//   s_valid/s_ready/s_data carry one transfer per item: func selects a received
//   byte (rx_byte) or a supervision tick. m_valid/m_ready/m_data return exactly
//   one result per item, in order.
//   cfg_wr_en/cfg_wr_data write max_missed_pings (reset value 3); write only
//   while no item is in flight.
// Path: an item passes the input register, then the result register; m_valid
//   rises when the item is in the result register.
// Throughput: one item per cycle while m_ready is high; link state is updated
//   in a single pass as the item moves from the input register to the result register.
// Stall: when m_ready is low the result register holds, the input register
//   fills and then s_ready drops; no item is lost or repeated.
// Reset: aresetn low clears both valid flags and the link state; s_ready is high
//   once reset has cleared the input valid flag, so an item can be taken as soon
//   as reset is released. The radio byte store is not cleared.
`default_nettype none

module remote_link_receiver_unit #(
    parameter int unsigned RADIO_BYTES = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rlr_pkg::rlr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rlr_pkg::rlr_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data
);
    import rlr_pkg::*;
    `include "remote_link_receiver_unit_defines.svh"

    logic                         in_valid_reg;
    rlr_in_t                      in_data_reg;
    logic                         out_valid_reg;
    rlr_out_t                     out_data_reg;
    rlr_state_t                   state_reg;
    rlr_state_t                   state_next;
    rlr_out_t                     res_next;
    logic [7:0]                   max_missed_reg;
    logic [RADIO_BYTES-1:0][7:0]  store_reg;
    logic                         store_we;
    logic                         adv;

    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    rlr_step #(
        .RADIO_BYTES(RADIO_BYTES)
    ) u_step (
        .st        (state_reg),
        .item      (in_data_reg),
        .max_missed(max_missed_reg),
        .store     (store_reg),
        .st_next   (state_next),
        .res       (res_next),
        .store_we  (store_we)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_missed_reg <= MAX_MISS_RST;
            state_reg      <= '{link_up: 1'b0, cmd_mode: CMD_NONE, param_index: '0,
                                missed: '0, pong: '0, div: '0, sup: 1'b0, hold: 1'b0};
        end else begin
            if (cfg_wr_en) begin
                max_missed_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv) begin
            out_data_reg <= res_next;
        end
        if (adv && store_we) begin
            store_reg[state_reg.param_index] <= in_data_reg.rx_byte;
        end
    end

    `RLR_ASSERT_NOW(a_idle_divider, !state_reg.sup, state_reg.div == 2'd0, "divider running while supervision stopped")
    `RLR_ASSERT_NOW(a_link_needs_sup, state_reg.link_up, state_reg.sup, "link up without supervision")
    `RLR_ASSERT_NOW(a_up_event, out_valid_reg && out_data_reg.link_event == EV_UP, out_data_reg.link_up && !out_data_reg.hold_on && out_data_reg.send_ping, "connect result inconsistent")
    `RLR_ASSERT_NOW(a_down_event, out_valid_reg && out_data_reg.link_event == EV_DOWN, !out_data_reg.link_up && !out_data_reg.hold_on && out_data_reg.send_ping, "drop result inconsistent")
    `RLR_ASSERT_NEXT(a_radio_done, adv && res_next.radio_valid, state_reg.cmd_mode == CMD_NONE && state_reg.param_index == '0, "radio command not closed")

endmodule

`default_nettype wire

FILE: sv/rlr_step.sv
// Next-state and result logic for one transfer of the remote link receiver.
// Depends on rlr_pkg.
`default_nettype none

module rlr_step #(
    parameter int unsigned RADIO_BYTES = 5
) (
    input  rlr_pkg::rlr_state_t                st,
    input  rlr_pkg::rlr_in_t                   item,
    input  logic [7:0]                         max_missed,
    input  logic [RADIO_BYTES-1:0][7:0]        store,
    output rlr_pkg::rlr_state_t                st_next,
    output rlr_pkg::rlr_out_t                  res,
    output logic                               store_we
);
    import rlr_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RADIO_BYTES - 1);

    logic [ACC_W-1:0] acc;
    logic [7:0]       missed_base;
    logic [7:0]       missed_inc;
    logic [7:0]       pong_base;
    logic [7:0]       c;

    assign c = item.rx_byte;

    always_comb begin
        acc = '0;
        for (int i = 0; i < RADIO_BYTES; i++) begin
            acc = {acc[ACC_W-9:0], (i == RADIO_BYTES - 1) ? c : store[i]};
        end
    end

    always_comb begin
        st_next     = st;
        res         = '0;
        store_we    = 1'b0;
        missed_base = st.missed;
        missed_inc  = st.missed;
        pong_base   = st.sup ? st.pong : 8'd0;

        if (item.func == FUNC_TICK) begin
            if (st.sup) begin
                if (st.div != DIV_LAST) begin
                    st_next.div = st.div + 2'd1;
                end else begin
                    st_next.div   = '0;
                    res.send_ping = 1'b1;
                    if (st.link_up) begin
                        missed_inc = (st.missed == CNT_SAT) ? CNT_SAT : st.missed + 8'd1;
                        st_next.missed = missed_inc;
                        if (missed_inc > max_missed) begin
                            st_next.link_up = 1'b0;
                            st_next.missed  = '0;
                            st_next.hold    = 1'b0;
                            st_next.pong    = '0;
                            st_next.sup     = 1'b0;
                            res.link_event  = EV_DOWN;
                        end
                    end else begin
                        if (st.pong > PONG_MIN) begin
                            st_next.cmd_mode    = CMD_NONE;
                            st_next.param_index = '0;
                            st_next.link_up     = 1'b1;
                            st_next.hold        = 1'b0;
                            st_next.pong        = '0;
                            missed_base         = '0;
                            res.link_event      = EV_UP;
                        end
                        missed_inc = missed_base + 8'd1;
                        if (missed_inc > SETUP_LIMIT) begin
                            st_next.missed = '0;
                            st_next.sup    = 1'b0;
                            st_next.pong   = '0;
                        end else begin
                            st_next.missed = missed_inc;
                        end
                    end
                end
            end
        end else if (!st.link_up) begin
            if (!st.sup) begin
                st_next.missed = '0;
                st_next.sup    = 1'b1;
            end
            if (c == CH_PONG && pong_base != CNT_SAT) begin
                st_next.pong = pong_base + 8'd1;
            end else begin
                st_next.pong = pong_base;
            end
        end else if (c == CH_PONG) begin
            st_next.param_index = '0;
            st_next.missed      = '0;
            st_next.cmd_mode    = CMD_NONE;
        end else if (c == CH_KEY) begin
            st_next.cmd_mode    = CMD_KEY;
            st_next.param_index = '0;
        end else if (c == CH_RADIO) begin
            st_next.cmd_mode    = CMD_RADIO;
            st_next.param_index = '0;
        end else begin
            case (st.cmd_mode)
                CMD_KEY: begin
                    if (c != CH_NUL) begin
                        if (c[HOLD_BIT]) begin
                            st_next.hold = ~st.hold;
                        end else begin
                            res.key_events = c[6:0];
                        end
                    end
                    st_next.cmd_mode = CMD_NONE;
                end
                CMD_RADIO: begin
                    store_we = 1'b1;
                    if (st.param_index == LAST_IDX) begin
                        st_next.param_index = '0;
                        st_next.cmd_mode    = CMD_NONE;
                        res.radio_valid     = 1'b1;
                        res.radio_word      = acc[39:0];
                    end else begin
                        st_next.param_index = st.param_index + IDX_W'(1);
                    end
                end
                default: begin
                    res.unknown_byte = (c != CH_NUL) && (c != CH_ETX);
                    st_next.cmd_mode = CMD_NONE;
                end
            endcase
        end

        res.hold_on = st_next.hold;
        res.link_up = st_next.link_up;
    end

endmodule

`default_nettype wire

FILE: bench/remote_link_receiver_unit_checker.sv
// Checker for the remote link receiver: predicts one result per input transfer
// and compares each result transfer field by field. Depends on rlr_pkg.
`timescale 1ns / 100ps

module remote_link_receiver_unit_checker #(
    parameter int unsigned FRAME_BYTES = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  rlr_pkg::rlr_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  rlr_pkg::rlr_out_t m_data,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    output int                errors,
    output int                pending,
    output int                n_results,
    output int                n_up,
    output int                n_down,
    output int                n_frames
);
    import rlr_pkg::*;

    localparam logic [IDX_W-1:0] FRAME_END = IDX_W'(FRAME_BYTES % 8);

    // predicted link state
    logic             linked;
    rlr_cmd_t         cmd;
    logic [IDX_W-1:0] pidx;
    logic [7:0]       frame_store [0:7];
    logic [7:0]       missed;
    logic [7:0]       pong;
    logic [1:0]       div;
    logic             sup;
    logic             hold;
    logic [7:0]       max_miss;

    rlr_out_t expected_results [$];

    task automatic step_link(input rlr_in_t it, output rlr_out_t r);
        logic [7:0]  c;
        logic [39:0] frame;
        r = '0;
        c = it.rx_byte;
        if (it.func == FUNC_TICK) begin
            if (sup) begin
                if (div != DIV_LAST) begin
                    div = div + 2'd1;
                end else begin
                    div = '0;
                    if (linked) begin
                        if (missed != CNT_SAT) missed = missed + 8'd1;
                        if (missed > max_miss) begin
                            linked = 1'b0;
                            missed = '0;
                            hold   = 1'b0;
                            pong   = '0;
                            sup    = 1'b0;
                            r.link_event = EV_DOWN;
                        end
                    end else begin
                        if (pong > PONG_MIN) begin
                            cmd    = CMD_NONE;
                            pidx   = '0;
                            linked = 1'b1;
                            missed = '0;
                            hold   = 1'b0;
                            pong   = '0;
                            r.link_event = EV_UP;
                        end
                        missed = missed + 8'd1;
                        if (missed > SETUP_LIMIT) begin
                            missed = '0;
                            sup    = 1'b0;
                            pong   = '0;
                        end
                    end
                    r.send_ping = 1'b1;
                end
            end
        end else if (!linked) begin
            if (!sup) begin
                pong   = '0;
                missed = '0;
                sup    = 1'b1;
            end
            if (c == CH_PONG && pong != CNT_SAT) pong = pong + 8'd1;
        end else if (c == CH_PONG) begin
            pidx   = '0;
            missed = '0;
            cmd    = CMD_NONE;
        end else if (c == CH_KEY) begin
            cmd  = CMD_KEY;
            pidx = '0;
        end else if (c == CH_RADIO) begin
            cmd  = CMD_RADIO;
            pidx = '0;
        end else if (cmd == CMD_KEY) begin
            if (c != CH_NUL) begin
                if (c[HOLD_BIT]) hold = ~hold;
                else r.key_events = c[6:0];
            end
            cmd = CMD_NONE;
        end else if (cmd == CMD_RADIO) begin
            frame_store[pidx] = c;
            pidx = pidx + 1'b1;
            if (pidx == FRAME_END) begin
                frame = '0;
                for (int i = 0; i < FRAME_BYTES; i++) begin
                    frame = (frame << 8) | 40'(frame_store[i % 8]);
                end
                r.radio_valid = 1'b1;
                r.radio_word  = frame;
                cmd = CMD_NONE;
            end
        end else begin
            if (c != CH_NUL && c != CH_ETX) r.unknown_byte = 1'b1;
            cmd = CMD_NONE;
        end
        r.hold_on = hold;
        r.link_up = linked;
    endtask

    function automatic void note_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : watch
        rlr_out_t want;
        rlr_out_t got;
        if (!aresetn) begin
            linked   = 1'b0;
            cmd      = CMD_NONE;
            pidx     = '0;
            missed   = '0;
            pong     = '0;
            div      = '0;
            sup      = 1'b0;
            hold     = 1'b0;
            max_miss = MAX_MISS_RST;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) max_miss = cfg_wr_data;
            if (s_valid && s_ready) begin
                step_link(s_data, want);
                expected_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_results.size() == 0) begin
                    errors++;
                    $error("result transfer with nothing expected: 0x%0h", got);
                end else begin
                    want = expected_results.pop_front();
                    n_results++;
                    if (want.link_event == EV_UP) n_up++;
                    if (want.link_event == EV_DOWN) n_down++;
                    if (want.radio_valid) n_frames++;
                    note_field("send_ping", 64'(want.send_ping), 64'(got.send_ping));
                    note_field("key_events", 64'(want.key_events), 64'(got.key_events));
                    note_field("hold_on", 64'(want.hold_on), 64'(got.hold_on));
                    note_field("link_event", 64'(want.link_event), 64'(got.link_event));
                    note_field("radio_valid", 64'(want.radio_valid), 64'(got.radio_valid));
                    note_field("radio_word", 64'(want.radio_word), 64'(got.radio_word));
                    note_field("unknown_byte", 64'(want.unknown_byte),
                               64'(got.unknown_byte));
                    note_field("link_up", 64'(want.link_up), 64'(got.link_up));
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

FILE: bench/remote_link_receiver_unit_tb.sv
// Top of the remote link receiver bench: clock, reset, stimulus and verdict.
// Depends on rlr_pkg, remote_link_receiver_unit and remote_link_receiver_unit_checker.
`timescale 1ns / 100ps

module remote_link_receiver_unit_tb;
    import rlr_pkg::*;

    localparam int unsigned FRAME_BYTES = 5;
    localparam int unsigned PHASE_ITEMS = 145;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    rlr_in_t    s_data;
    logic       m_valid;
    logic       m_ready;
    rlr_out_t   m_data;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    int errors, pending, n_results, n_up, n_down, n_frames;
    int sent;
    int settings_used;
    bit quiet_tx;
    bit quiet_rx;
    logic [7:0] limits [0:6];

    always #5 aclk = ~aclk;

    remote_link_receiver_unit #(.RADIO_BYTES(FRAME_BYTES)) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    remote_link_receiver_unit_checker #(.FRAME_BYTES(FRAME_BYTES)) chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .errors     (errors),
        .pending    (pending),
        .n_results  (n_results),
        .n_up       (n_up),
        .n_down     (n_down),
        .n_frames   (n_frames)
    );

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // entered and left at a rising edge; leaves after the transfer
    task automatic push_item(input logic func, input logic [7:0] b);
        rlr_in_t it;
        int gap;
        it.func    = func;
        it.rx_byte = b;
        gap = pick_gap(quiet_tx);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(FUNC_BYTE, b);
    endtask

    task automatic push_tick();
        push_item(FUNC_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    // pongs then enough ticks to reach a ping; a ping with the link down brings it up
    task automatic connect_link();
        repeat ($urandom_range(2, 4)) push_byte(CH_PONG);
        repeat ($urandom_range(4, 8)) push_tick();
    endtask

    task automatic run_sequence();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 15) == 0) quiet_tx = !quiet_tx;
        if (r < 12) begin
            if ($urandom_range(0, 2) == 0) push_byte(8'($urandom_range(0, 255)));
            connect_link();
        end else if (r < 32) begin
            push_byte(CH_KEY);
            case ($urandom_range(0, 3))
                0: push_byte(CH_NUL);
                1: push_byte({1'b1, 7'($urandom_range(0, 127))});
                default: push_byte(8'($urandom_range(1, 127)));
            endcase
        end else if (r < 52) begin
            push_byte(CH_RADIO);
            if ($urandom_range(0, 5) == 0) begin
                k = $urandom_range(0, FRAME_BYTES - 1);
                repeat (k) push_byte(8'($urandom_range(0, 255)));
                case ($urandom_range(0, 2))
                    0: push_byte(CH_KEY);
                    1: push_byte(CH_PONG);
                    default: push_byte(CH_RADIO);
                endcase
            end else begin
                repeat (FRAME_BYTES) push_byte(8'($urandom_range(0, 255)));
            end
        end else if (r < 62) begin
            push_byte(CH_PONG);
        end else if (r < 77) begin
            repeat ($urandom_range(1, 6)) push_tick();
        end else if (r < 90) begin
            case ($urandom_range(0, 3))
                0: push_byte(CH_NUL);
                1: push_byte(CH_ETX);
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end else begin
            push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic directed_items();
        push_tick();                 // supervision not running yet
        push_byte(CH_NUL);           // starts supervision
        repeat (3) push_byte(CH_PONG);
        repeat (4) push_tick();      // ping, link comes up
        push_byte(CH_KEY);
        push_byte(CH_NUL);           // key byte zero
        push_byte(CH_KEY);
        push_byte(8'h85);            // hold toggle
        push_byte(CH_KEY);
        push_byte(8'h7F);
        push_byte(CH_RADIO);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hA5);
        push_byte(8'h5A);
        push_byte(8'h01);
        push_byte(CH_ETX);
        push_byte(CH_NUL);
        push_byte(8'hFF);
        push_byte(CH_PONG);
    endtask

    initial begin : rx_side
        int run;
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            run = $urandom_range(1, 20);
            repeat (run) @(posedge aclk);
            if ($urandom_range(0, 15) == 0) quiet_rx = !quiet_rx;
            gap = pick_gap(quiet_rx);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int start;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        limits[0] = 8'd0;
        limits[1] = 8'd1;
        limits[2] = 8'd254;
        limits[3] = 8'd255;
        limits[4] = 8'($urandom_range(2, 253));
        limits[5] = 8'($urandom_range(2, 253));
        limits[6] = MAX_MISS_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_items();
        drain();

        for (int i = 0; i < 7; i++) begin
            write_limit(limits[i]);
            if (limits[i] == 8'd0) begin
                // settle down with supervision stopped, then drive the pong count into saturation
                repeat (12) push_tick();
                repeat (270) push_byte(CH_PONG);
                repeat (4) push_tick();
            end
            start = sent;
            while (sent - start < PHASE_ITEMS) run_sequence();
            drain();
        end

        $display("Covered %0d input transfers under %0d limit settings, %0d results checked.",
                 sent, settings_used + 1, n_results);
        $display("Link came up %0d times, dropped %0d times, %0d radio frames reported.",
                 n_up, n_down, n_frames);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
